FILE: src/sbp_pkg.sv
// Package for the six-button pad reader.
// Holds the transaction structs, per-port state struct, bit positions and the hat encoder.
// No dependencies.
package sbp_pkg;

    localparam logic [1:0] SKIP_TICKS = 2'd2;

    // Button bit positions.
    localparam int BTN_A     = 0;
    localparam int BTN_B     = 1;
    localparam int BTN_C     = 2;
    localparam int BTN_X     = 3;
    localparam int BTN_Y     = 4;
    localparam int BTN_Z     = 5;
    localparam int BTN_START = 6;
    localparam int BTN_MODE  = 7;
    localparam int BTN_HOME  = 8;

    // Direction bit positions.
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    // Pin bit positions.
    localparam int PIN_D0 = 0;
    localparam int PIN_D1 = 1;
    localparam int PIN_D2 = 2;
    localparam int PIN_D3 = 3;
    localparam int PIN_TL = 4;
    localparam int PIN_TR = 5;

    localparam logic [8:0] MENU_BUTTONS = 9'b1_0000_0000;

    localparam logic [3:0] HAT_CENTER     = 4'd0;
    localparam logic [3:0] HAT_UP         = 4'd1;
    localparam logic [3:0] HAT_UP_RIGHT   = 4'd2;
    localparam logic [3:0] HAT_RIGHT      = 4'd3;
    localparam logic [3:0] HAT_DOWN_RIGHT = 4'd4;
    localparam logic [3:0] HAT_DOWN       = 4'd5;
    localparam logic [3:0] HAT_DOWN_LEFT  = 4'd6;
    localparam logic [3:0] HAT_LEFT       = 4'd7;
    localparam logic [3:0] HAT_UP_LEFT    = 4'd8;

    typedef struct packed {
        logic       port;
        logic [5:0] pins;
    } t_in;

    typedef struct packed {
        logic       select_level;
        logic [3:0] dpad;
        logic [8:0] buttons;
        logic       pad_present;
        logic       changed;
        logic [3:0] hat;
        logic       menu_combo;
    } t_out;

    typedef struct packed {
        logic       select_phase;
        logic       present_flag;
        logic       six_mode_flag;
        logic [1:0] skip_count;
        logic [8:0] button_bits;
        logic [3:0] direction_bits;
        logic [8:0] reported_buttons;
        logic [3:0] reported_directions;
    } t_port_state;

    // After reset the select line is high and everything else is clear.
    localparam t_port_state PORT_RESET =
        t_port_state'({1'b1, {($bits(t_port_state) - 1){1'b0}}});

    // Down wins over up, right wins over left.
    function automatic logic [3:0] hat_code(input logic [3:0] d);
        logic [3:0] code;
        if (d[DIR_DOWN]) begin
            code = d[DIR_RIGHT] ? HAT_DOWN_RIGHT : (d[DIR_LEFT] ? HAT_DOWN_LEFT : HAT_DOWN);
        end else if (d[DIR_UP]) begin
            code = d[DIR_RIGHT] ? HAT_UP_RIGHT : (d[DIR_LEFT] ? HAT_UP_LEFT : HAT_UP);
        end else begin
            code = d[DIR_RIGHT] ? HAT_RIGHT : (d[DIR_LEFT] ? HAT_LEFT : HAT_CENTER);
        end
        return code;
    endfunction

endpackage

FILE: src/sbp_tick.sv
// Per-tick decode for one port of the six-button pad reader.
// Takes one port's state and pin levels, gives the next state and the result.
// Depends on sbp_pkg.
module sbp_tick (
    input  sbp_pkg::t_port_state i_state,
    input  logic [5:0]           i_pins,
    output sbp_pkg::t_port_state o_state,
    output sbp_pkg::t_out        o_result
);
    import sbp_pkg::*;

    logic [5:0] low;
    logic       sel;
    logic [8:0] b;
    logic [3:0] d;
    logic       chg;
    logic       menu;

    assign low = ~i_pins;
    assign sel = ~i_state.select_phase;

    always_comb begin
        o_state = i_state;
        o_state.select_phase = sel;
        b = i_state.button_bits;
        d = i_state.direction_bits;

        if (i_state.skip_count != 2'd0) begin
            // Skipped ticks only sample Home, and only on the first one.
            if (i_state.skip_count == SKIP_TICKS) begin
                b[BTN_HOME] = low[PIN_D0];
            end
            o_state.skip_count = i_state.skip_count - 2'd1;
        end else if (sel) begin
            if (i_state.present_flag) begin
                if (i_state.six_mode_flag) begin
                    b[BTN_Z]    = low[PIN_D0];
                    b[BTN_Y]    = low[PIN_D1];
                    b[BTN_X]    = low[PIN_D2];
                    b[BTN_MODE] = low[PIN_D3];
                    o_state.six_mode_flag = 1'b0;
                    o_state.skip_count    = SKIP_TICKS;
                end else begin
                    d = low[3:0];
                    b[BTN_B] = low[PIN_TL];
                    b[BTN_C] = low[PIN_TR];
                end
            end else begin
                // Two-fire-button pad: fire 1 is A, fire 2 is B.
                d = low[3:0];
                b = '0;
                b[BTN_A] = low[PIN_TL];
                b[BTN_B] = low[PIN_TR];
            end
        end else begin
            o_state.present_flag  = low[PIN_D2] & low[PIN_D3];
            o_state.six_mode_flag = low[PIN_D0] & low[PIN_D1];
            if (o_state.present_flag && !o_state.six_mode_flag) begin
                b[BTN_A]     = low[PIN_TL];
                b[BTN_START] = low[PIN_TR];
            end
        end

        chg  = (b != i_state.reported_buttons) || (d != i_state.reported_directions);
        menu = b[BTN_START] & d[DIR_DOWN];

        o_state.button_bits         = b;
        o_state.direction_bits      = d;
        o_state.reported_buttons    = b;
        o_state.reported_directions = d;

        o_result.select_level = sel;
        o_result.dpad         = d;
        o_result.buttons      = menu ? MENU_BUTTONS : b;
        o_result.pad_present  = o_state.present_flag;
        o_result.changed      = chg;
        o_result.hat          = menu ? HAT_CENTER : hat_code(d);
        o_result.menu_combo   = menu;
    end

endmodule

FILE: src/six_button_pad_reader.sv
// Six-button pad reader top level: input register, per-port state, result register.
// A transaction passes the input register, then the result register.
// One transaction per cycle unless stalled; per-port state update is a single pass.
// Reset (synchronous, active low): every port's select phase goes high, all other
// per-port state clears, and both pipeline registers empty.
// Depends on sbp_pkg and sbp_tick.
module six_button_pad_reader #(
    parameter int PORTS = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sbp_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sbp_pkg::t_out o_out_data
);
    import sbp_pkg::*;

    logic        r_in_valid;
    t_in         r_in;
    logic        r_out_valid;
    t_out        r_out;
    t_port_state r_state [PORTS];

    t_port_state cur_state;
    t_port_state nxt_state;
    t_out        tick_result;
    logic        port_ok;
    logic        advance;

    always_comb begin
        cur_state = r_state[0];
        for (int i = 0; i < PORTS; i++) begin
            if (int'(r_in.port) == i) begin
                cur_state = r_state[i];
            end
        end
    end

    assign port_ok    = int'(r_in.port) < PORTS;
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    sbp_tick u_tick (
        .i_state  (cur_state),
        .i_pins   (r_in.pins),
        .o_state  (nxt_state),
        .o_result (tick_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < PORTS; i++) begin
                r_state[i] <= PORT_RESET;
            end
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                // A port outside the configured range leaves all per-port state untouched.
                if (r_in_valid && port_ok) begin
                    for (int i = 0; i < PORTS; i++) begin
                        if (int'(r_in.port) == i) begin
                            r_state[i] <= nxt_state;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance && r_in_valid) begin
            r_out <= port_ok ? tick_result : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
